// File: rtl/tcbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbps_pkg
// Shared types and constants for the two-color block pair selector.
// ----------------------------------------------------------------------------
package tcbps_pkg;

  localparam int PIX_PER_BLK  = 8;
  localparam int PIX_W        = 36;
  localparam int CHAN_BITS    = 12;
  localparam int NUM_CHAN     = 3;
  localparam int PAL_SIZE     = 16;
  localparam int IDX_W        = 4;
  localparam int MAP_W        = 8;
  localparam int LEVEL_W      = 8;

  localparam logic [IDX_W-1:0] PAL_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] PAL_LAST  = 4'd15;

  // R, G, B levels per entry
  localparam logic [23:0] PALETTE [PAL_SIZE] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
    24'h808080, 24'hFF8080, 24'h80FF80, 24'hFFFF80,
    24'h8080FF, 24'hFF80FF, 24'h80FFFF, 24'hFF8000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_PICK,
    ST_CMP,
    ST_FLUSH
  } state_t;

  // channel 0 = R, 1 = G, 2 = B
  function automatic logic [LEVEL_W-1:0] pal_level(input logic [IDX_W-1:0] idx,
                                                   input logic [1:0] ch);
    logic [23:0] entry;
    entry = PALETTE[idx];
    unique case (ch)
      2'd0:    pal_level = entry[23:16];
      2'd1:    pal_level = entry[15:8];
      default: pal_level = entry[7:0];
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/tcbps_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbps_pix_if
// Input channel: one block of eight packed RGB pixels per item.
// ----------------------------------------------------------------------------
interface tcbps_pix_if;
  logic                     valid;
  logic                     ready;
  logic [tcbps_pkg::PIX_W-1:0] pixel_0;
  logic [tcbps_pkg::PIX_W-1:0] pixel_1;
  logic [tcbps_pkg::PIX_W-1:0] pixel_2;
  logic [tcbps_pkg::PIX_W-1:0] pixel_3;
  logic [tcbps_pkg::PIX_W-1:0] pixel_4;
  logic [tcbps_pkg::PIX_W-1:0] pixel_5;
  logic [tcbps_pkg::PIX_W-1:0] pixel_6;
  logic [tcbps_pkg::PIX_W-1:0] pixel_7;

  modport source (
    output valid, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7,
    input  ready
  );
  modport sink (
    input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/tcbps_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbps_res_if
// Output channel: winning color pair and bitmap per item.
// ----------------------------------------------------------------------------
interface tcbps_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcbps_pkg::IDX_W-1:0] first_color;
  logic [tcbps_pkg::IDX_W-1:0] second_color;
  logic [tcbps_pkg::MAP_W-1:0] bitmap;

  modport source (
    output valid, first_color, second_color, bitmap,
    input  ready
  );
  modport sink (
    input  valid, first_color, second_color, bitmap,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/two_color_block_pair_select_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_color_block_pair_select_top
// Picks the best pair of palette colors for an 8-pixel block, scoring each
// pair by in-block error diffusion (7/16 carried right).
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake     Payload
// pixels    in    valid/ready   pixel_0..pixel_7, 36b each, R|G|B unsigned
// result    out   valid/ready   first_color 4b, second_color 4b, bitmap 8b
//
// Search: each pixel step runs on the shared step unit as ST_SQR (square),
//   then ST_PICK (pick/carry), and each of the 136 pairs ends in ST_CMP;
//   ST_FLUSH then moves the winner into the output register, and ST_IDLE
//   takes the next item.
// The block takes no new item while a search runs; it takes the next item
//   as soon as the winner sits in the output register, even if unread.
// A finished search waits in ST_FLUSH while an older result is unread.
// Reset (rst, synchronous) clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
module two_color_block_pair_select_top #(
  parameter int FRAC_BITS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tcbps_pix_if.sink     pixels,
  tcbps_res_if.source   result
);
  import tcbps_pkg::*;

  // Working channel width: palette full scale or input full scale, plus
  // headroom for diffused error (bounded near 16/9 of full scale) and sign.
  localparam int BASE_W = (LEVEL_W + FRAC_BITS > CHAN_BITS) ?
                          (LEVEL_W + FRAC_BITS) : CHAN_BITS;
  localparam int VW     = BASE_W + 3;
  localparam int SQW    = 2 * VW;       // one squared channel error
  localparam int SW     = SQW + 2;      // sum of three
  localparam int SCW    = SW + 7;       // block score, scaled by 16
  localparam int CW     = VW + 4;       // 7*e + 8 before the shift
  localparam int PI_W   = $clog2(PIX_PER_BLK);

  localparam logic [PI_W-1:0] PIX_LAST = PI_W'(PIX_PER_BLK - 1);

  typedef logic signed [VW-1:0] chan_t;

  // --------------------------------------------------------------------------
  // Sequencer state and registers
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic [PIX_W-1:0]  ring [PIX_PER_BLK];    // rotates once per pixel step
  chan_t             cur  [NUM_CHAN];       // working pixel incl. carry
  logic [SQW-1:0]    sq_a [NUM_CHAN];
  logic [SQW-1:0]    sq_b [NUM_CHAN];
  chan_t             nxt_a [NUM_CHAN];      // next working pixel if a picked
  chan_t             nxt_b [NUM_CHAN];
  logic [PI_W-1:0]   pix_idx;
  logic [IDX_W-1:0]  col_a;
  logic [IDX_W-1:0]  col_b;
  logic [MAP_W-1:0]  map;
  logic [SCW-1:0]    score;
  logic [SCW-1:0]    best_score;
  logic [IDX_W-1:0]  best_a;
  logic [IDX_W-1:0]  best_b;
  logic [MAP_W-1:0]  best_map;

  logic              res_valid;
  logic [IDX_W-1:0]  res_first;
  logic [IDX_W-1:0]  res_second;
  logic [MAP_W-1:0]  res_map;

  // control decode
  logic in_ready, do_sqr, do_pick, do_cmp, do_flush;
  logic load, last_pix, last_pair, first_pair, out_free;

  assign load       = pixels.valid & in_ready;
  assign last_pix   = (pix_idx == PIX_LAST);
  assign last_pair  = (col_a == PAL_LAST) && (col_b == PAL_LAST);
  assign first_pair = (col_a == PAL_FIRST) && (col_b == PAL_FIRST);
  assign out_free   = !res_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (pixels.valid) state_next = ST_SQR;
      ST_SQR:   state_next = ST_PICK;
      ST_PICK:  state_next = last_pix ? ST_CMP : ST_SQR;
      ST_CMP:   state_next = last_pair ? ST_FLUSH : ST_SQR;
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    do_sqr   = 1'b0;
    do_pick  = 1'b0;
    do_cmp   = 1'b0;
    do_flush = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SQR:   do_sqr   = 1'b1;
      ST_PICK:  do_pick  = 1'b1;
      ST_CMP:   do_cmp   = 1'b1;
      ST_FLUSH: do_flush = out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Step unit, phase 1: per-channel error to both colors, squared, and the
  // diffused next pixel for either choice.
  // --------------------------------------------------------------------------
  function automatic chan_t pal_val(input logic [IDX_W-1:0] idx, input logic [1:0] ch);
    pal_val = chan_t'(VW'(pal_level(idx, ch)) << FRAC_BITS);
  endfunction

  function automatic chan_t chan_of(input logic [PIX_W-1:0] p, input int ch);
    chan_of = chan_t'(p[(NUM_CHAN - 1 - ch) * CHAN_BITS +: CHAN_BITS]);
  endfunction

  // floor((7 * e + 8) / 16)
  function automatic chan_t carry_of(input chan_t e);
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] t;
    ex = CW'(e);
    t  = (ex <<< 3) - ex + CW'(8);
    carry_of = chan_t'(t >>> 4);
  endfunction

  chan_t              d_a [NUM_CHAN];
  chan_t              d_b [NUM_CHAN];
  logic signed [SQW-1:0] p_a [NUM_CHAN];
  logic signed [SQW-1:0] p_b [NUM_CHAN];
  chan_t              n_a [NUM_CHAN];
  chan_t              n_b [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      d_a[c] = cur[c] - pal_val(col_a, 2'(c));
      d_b[c] = cur[c] - pal_val(col_b, 2'(c));
      p_a[c] = SQW'(d_a[c]) * SQW'(d_a[c]);
      p_b[c] = SQW'(d_b[c]) * SQW'(d_b[c]);
      n_a[c] = chan_of(ring[1], c) + carry_of(d_a[c]);
      n_b[c] = chan_of(ring[1], c) + carry_of(d_b[c]);
    end
  end

  // --------------------------------------------------------------------------
  // Step unit, phase 2: distance sums, nearer color (tie to a), weighted
  // score update.
  // --------------------------------------------------------------------------
  logic [SW-1:0]  dist_a, dist_b, mag;
  logic           pick_a;
  logic [SCW-1:0] weighted, score_next;

  always_comb begin
    dist_a   = SW'(sq_a[0]) + SW'(sq_a[1]) + SW'(sq_a[2]);
    dist_b   = SW'(sq_b[0]) + SW'(sq_b[1]) + SW'(sq_b[2]);
    pick_a   = (dist_a <= dist_b);
    mag      = pick_a ? dist_a : dist_b;
    // last pixel counts in full (16/16), the others 9/16
    weighted = last_pix ? (SCW'(mag) << 4) : ((SCW'(mag) << 3) + SCW'(mag));
    score_next = ((pix_idx == '0) ? '0 : score) + weighted;
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load) begin
      ring[0] <= pixels.pixel_0;
      ring[1] <= pixels.pixel_1;
      ring[2] <= pixels.pixel_2;
      ring[3] <= pixels.pixel_3;
      ring[4] <= pixels.pixel_4;
      ring[5] <= pixels.pixel_5;
      ring[6] <= pixels.pixel_6;
      ring[7] <= pixels.pixel_7;
      for (int c = 0; c < NUM_CHAN; c++) begin
        cur[c] <= chan_t'(pixels.pixel_0[(NUM_CHAN - 1 - c) * CHAN_BITS +: CHAN_BITS]);
      end
      pix_idx <= '0;
      col_a   <= PAL_FIRST;
      col_b   <= PAL_FIRST;
    end

    if (do_sqr) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        sq_a[c]  <= p_a[c];
        sq_b[c]  <= p_b[c];
        nxt_a[c] <= n_a[c];
        nxt_b[c] <= n_b[c];
      end
    end

    if (do_pick) begin
      // ring[1] holds pixel 0 again on the last step: restart with no carry
      for (int c = 0; c < NUM_CHAN; c++) begin
        cur[c] <= last_pix ? chan_of(ring[1], c) : (pick_a ? nxt_a[c] : nxt_b[c]);
      end
      for (int k = 0; k < PIX_PER_BLK - 1; k++) begin
        ring[k] <= ring[k + 1];
      end
      ring[PIX_PER_BLK - 1] <= ring[0];
      map     <= {map[MAP_W-2:0], pick_a};
      score   <= score_next;
      pix_idx <= pix_idx + 1'b1;
    end

    if (do_cmp) begin
      // strict less-than keeps the earlier pair on a tie
      if (first_pair || (score < best_score)) begin
        best_score <= score;
        best_a     <= col_a;
        best_b     <= col_b;
        best_map   <= map;
      end
      if (col_b == PAL_LAST) begin
        col_a <= col_a + 1'b1;
        col_b <= col_a + 1'b1;
      end else begin
        col_b <= col_b + 1'b1;
      end
    end

    if (do_flush) begin
      res_first  <= best_a;
      res_second <= best_b;
      res_map    <= best_map;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_flush) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign pixels.ready        = in_ready;
  assign result.valid        = res_valid;
  assign result.first_color  = res_first;
  assign result.second_color = res_second;
  assign result.bitmap       = res_map;

endmodule
`default_nettype wire

// File: tb/sv/tb_two_color_block_pair_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_color_block_pair_select_top
// Self-checking bench for the two-color block pair selector. Blocks of eight
// pixels go in through a queue-fed driver. A bit-exact pair search in the
// bench predicts each result. A monitor checks every returned item against
// the oldest prediction. Both sides idle in random bursts, and the receiver
// holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_two_color_block_pair_select_top;
  import tcbps_pkg::*;

  localparam int FRAC         = 4;
  localparam int HALF_PERIOD  = 6;
  localparam int N_RANDOM     = 550;
  localparam int TAIL_ITEMS   = 40;        // no idling once this few are left
  localparam int HOLD_AT      = 30;        // blocks in before the long hold-off
  localparam int HOLD_CYCLES  = 8000;      // > 3 searches, so input stalls
  localparam int DRAIN_CYCLES = 2500;      // about one search of quiet at the end
  localparam int CYCLE_LIMIT  = 4_000_000; // ~3x the slowest correct run
  localparam int MAX_REPORTS  = 60;
  localparam int CHAN_TOP     = (1 << CHAN_BITS) - 1;

  typedef logic [PIX_PER_BLK-1:0][PIX_W-1:0] block_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic [MAP_W-1:0] bitmap;
  } color_pair_t;

  logic clk;
  logic rst;

  tcbps_pix_if pix_bus ();
  tcbps_res_if res_bus ();

  two_color_block_pair_select_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .pixels(pix_bus),
    .result(res_bus)
  );

  block_t      pending_blocks [$];
  color_pair_t expected_pairs [$];

  int   n_blocks;
  int   blocks_in;
  int   errors;
  int   cycles;
  int   src_gap;
  int   snk_gap;
  int   hold_left;
  logic hold_done;
  logic in_taken;   // input handshake seen at the last rising edge

  // Idling stops for the tail of the run.
  function automatic logic calm();
    return pending_blocks.size() < TAIL_ITEMS;
  endfunction

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Palette channel in working units (level scaled by 2^FRAC).
  function automatic longint pal_fx(int idx, int ch);
    logic [23:0] entry;
    entry = PALETTE[idx];
    return longint'(entry[23 - 8*ch -: 8]) << FRAC;
  endfunction

  function automatic longint sq_dist(longint v [NUM_CHAN], int idx);
    longint d;
    longint acc;
    acc = 0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      d = v[ch] - pal_fx(idx, ch);
      acc += d * d;
    end
    return acc;
  endfunction

  // Full search over all pairs lo <= hi with in-block error diffusion.
  // Scores are kept scaled by 16 (9x for pixels 0..6, 16x for pixel 7), so
  // comparison is exact; strict < keeps the earliest pair on a tie.
  function automatic color_pair_t best_pair(block_t blk);
    longint           px [PIX_PER_BLK][NUM_CHAN];
    longint           cur [NUM_CHAN];
    longint           carry [NUM_CHAN];
    longint           score;
    longint           best_score;
    longint           mag;
    longint           e;
    logic [MAP_W-1:0] map;
    int               pick;
    color_pair_t      best;
    for (int i = 0; i < PIX_PER_BLK; i++)
      for (int ch = 0; ch < NUM_CHAN; ch++)
        px[i][ch] = blk[i][CHAN_BITS*(NUM_CHAN-1-ch) +: CHAN_BITS];
    best_score = 64'h7FFF_FFFF_FFFF_FFFF;
    best       = '0;
    for (int a = 0; a < PAL_SIZE; a++) begin
      for (int b = a; b < PAL_SIZE; b++) begin
        score = 0;
        map   = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) carry[ch] = 0;
        for (int i = 0; i < PIX_PER_BLK; i++) begin
          for (int ch = 0; ch < NUM_CHAN; ch++) cur[ch] = px[i][ch] + carry[ch];
          // equal distance goes to the lower color
          if (sq_dist(cur, a) <= sq_dist(cur, b)) begin
            pick = a;
            map[MAP_W-1-i] = 1'b1;
          end else begin
            pick = b;
          end
          mag = 0;
          for (int ch = 0; ch < NUM_CHAN; ch++) begin
            e = cur[ch] - pal_fx(pick, ch);
            mag += e * e;
            carry[ch] = (7 * e + 8) >>> 4;   // 7/16, rounded half up
          end
          score += (i == PIX_PER_BLK - 1) ? 16 * mag : 9 * mag;
        end
        if (score < best_score) begin
          best_score  = score;
          best.lo_idx = IDX_W'(a);
          best.hi_idx = IDX_W'(b);
          best.bitmap = map;
        end
      end
    end
    return best;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [PIX_W-1:0] rgb(int r, int g, int b);
    return {CHAN_BITS'(r), CHAN_BITS'(g), CHAN_BITS'(b)};
  endfunction

  // base +/- spread, clamped to the channel range
  function automatic int jitter(longint base, int spread);
    longint v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > CHAN_TOP) v = CHAN_TOP;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] near_color(int idx, int spread);
    return rgb(jitter(pal_fx(idx, 0), spread), jitter(pal_fx(idx, 1), spread),
               jitter(pal_fx(idx, 2), spread));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new item at the falling edge once the last one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    block_t nxt;
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else if (!pix_bus.valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap = src_gap - 1;
        pix_bus.valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        nxt = pending_blocks.pop_front();
        pix_bus.pixel_0 <= nxt[0];
        pix_bus.pixel_1 <= nxt[1];
        pix_bus.pixel_2 <= nxt[2];
        pix_bus.pixel_3 <= nxt[3];
        pix_bus.pixel_4 <= nxt[4];
        pix_bus.pixel_5 <= nxt[5];
        pix_bus.pixel_6 <= nxt[6];
        pix_bus.pixel_7 <= nxt[7];
        pix_bus.valid   <= 1'b1;
        if (!calm() && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 12);
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: random bursts of stall, plus the long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap = snk_gap - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      if (!calm() && $urandom_range(0, 15) == 0) snk_gap = $urandom_range(1, 12);
    end
  end

  // Long hold-off, counted here. The sender keeps offering meanwhile, so the
  // output register and the flush slot fill and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && blocks_in == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input handshake, check on output handshake
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    color_pair_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      blocks_in <= 0;
    end else begin
      in_taken <= pix_bus.valid && pix_bus.ready;
      if (pix_bus.valid && pix_bus.ready) begin
        expected_pairs.push_back(best_pair({pix_bus.pixel_7, pix_bus.pixel_6,
                                            pix_bus.pixel_5, pix_bus.pixel_4,
                                            pix_bus.pixel_3, pix_bus.pixel_2,
                                            pix_bus.pixel_1, pix_bus.pixel_0}));
        blocks_in <= blocks_in + 1;
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_pairs.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%t unexpected item: expected none, actual %0d/%0d/%02h", $time,
                     res_bus.first_color, res_bus.second_color, res_bus.bitmap);
        end else begin
          want = expected_pairs.pop_front();
          if (res_bus.first_color !== want.lo_idx) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%t first_color mismatch: expected %0d, actual %0d", $time,
                       want.lo_idx, res_bus.first_color);
          end
          if (res_bus.second_color !== want.hi_idx) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%t second_color mismatch: expected %0d, actual %0d", $time,
                       want.hi_idx, res_bus.second_color);
          end
          if (res_bus.bitmap !== want.bitmap) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%t bitmap mismatch: expected %02h, actual %02h", $time,
                       want.bitmap, res_bus.bitmap);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("two_color_block_pair_select_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset, end of run
  // --------------------------------------------------------------------------
  initial begin
    block_t           blk;
    int               kind;
    int               ca;
    int               cb;
    int               spread;
    logic [MAP_W-1:0] pat;

    clk           = 1'b0;
    rst           = 1'b1;
    cycles        = 0;
    errors        = 0;
    src_gap       = 0;
    snk_gap       = 0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_0 = '0;
    pix_bus.pixel_1 = '0;
    pix_bus.pixel_2 = '0;
    pix_bus.pixel_3 = '0;
    pix_bus.pixel_4 = '0;
    pix_bus.pixel_5 = '0;
    pix_bus.pixel_6 = '0;
    pix_bus.pixel_7 = '0;
    res_bus.ready = 1'b0;

    // ---- directed ----
    // all zero: uniform black block, pair (0,0) wins with every bit set
    pending_blocks.push_back('0);
    // channels at full scale, beyond white
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = rgb(CHAN_TOP, CHAN_TOP, CHAN_TOP);
    pending_blocks.push_back(blk);
    // uniform exact palette colors
    foreach (PALETTE[k]) begin
      if (k == 7 || k == 8 || k == 12 || k == 15) begin
        for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color(k, 0);
        pending_blocks.push_back(blk);
      end
    end
    // exact midpoint between black and white: equal distances
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = rgb(2040, 2040, 2040);
    pending_blocks.push_back(blk);
    // alternating black / white
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color((i % 2) ? 7 : 0, 0);
    pending_blocks.push_back(blk);
    // red / cyan in a fixed pattern
    pat = 8'b1011_0010;
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color(pat[i] ? 1 : 6, 0);
    pending_blocks.push_back(blk);
    // alternating bit patterns, every bit both ways
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = (i % 2) ? 36'hAAAAAAAAA : 36'h555555555;
    pending_blocks.push_back(blk);
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = (i % 2) ? 36'h555555555 : 36'hAAAAAAAAA;
    pending_blocks.push_back(blk);
    // every pixel a different color
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color(2 * i + 1, 0);
    pending_blocks.push_back(blk);
    // grey ramp over the full range
    for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = rgb(i * 585, i * 585, i * 585);
    pending_blocks.push_back(blk);
    // a few noisy two-color blocks
    for (int n = 0; n < 3; n++) begin
      ca = $urandom_range(0, PAL_SIZE - 1);
      cb = $urandom_range(0, PAL_SIZE - 1);
      for (int i = 0; i < PIX_PER_BLK; i++)
        blk[i] = near_color($urandom_range(0, 1) ? ca : cb, 24);
      pending_blocks.push_back(blk);
    end

    // ---- random ----
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // raw 36-bit words
        for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = PIX_W'({$urandom(), $urandom()});
      end else if (kind <= 7) begin
        // two palette colors plus noise, sometimes exact
        ca     = $urandom_range(0, PAL_SIZE - 1);
        cb     = $urandom_range(0, PAL_SIZE - 1);
        spread = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 200);
        pat    = MAP_W'($urandom());
        for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color(pat[i] ? ca : cb, spread);
      end else begin
        // one color with wide per-pixel spread
        ca     = $urandom_range(0, PAL_SIZE - 1);
        spread = $urandom_range(0, 600);
        for (int i = 0; i < PIX_PER_BLK; i++) blk[i] = near_color(ca, spread);
      end
      pending_blocks.push_back(blk);
    end
    n_blocks = pending_blocks.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (blocks_in != n_blocks || expected_pairs.size() != 0) @(posedge clk);
    // quiet period: any stray result still gets flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("two_color_block_pair_select_top regression: pass");
    end else begin
      $display("two_color_block_pair_select_top regression: fail");
    end
    $finish;
  end

endmodule

// File: two_color_block_pair_select_top.f
rtl/tcbps_pkg.sv
rtl/tcbps_pix_if.sv
rtl/tcbps_res_if.sv
rtl/two_color_block_pair_select_top.sv
tb/sv/tb_two_color_block_pair_select_top.sv
